>>> design/ptd_pkg.sv
// ptd_pkg: shared types and constants for the priority timed event dispatcher
// table entry layout, compare unit request/response, sequencer states, op codes
// no dependencies
`default_nettype none

package ptd_pkg;

   localparam int MAX_HANDLERS_DEF = 16;
   localparam logic [31:0] HORIZON_RESET = 32'd3600000;

   localparam int OP_W   = 2;
   localparam int ID_W   = 4;
   localparam int PRIO_W = 8;
   localparam int TIME_W = 32;

   localparam logic [OP_W-1:0] OP_ADD  = 2'd0;
   localparam logic [OP_W-1:0] OP_SET  = 2'd1;
   localparam logic [OP_W-1:0] OP_TICK = 2'd2;

   typedef struct packed {
      logic [ID_W-1:0]   id;
      logic [PRIO_W-1:0] prio;
      logic [TIME_W-1:0] tstamp;
   } entry_type;

   typedef struct packed {
      logic [TIME_W-1:0] lhs;
      logic [TIME_W-1:0] rhs;
   } cmp_req_type;

   typedef struct packed {
      logic              lt;
      logic [TIME_W-1:0] min_val;
      logic [TIME_W-1:0] max_val;
   } cmp_rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INS_RD,
      ST_INS_EX,
      ST_SET_RD,
      ST_SET_EX,
      ST_WAKE_RD,
      ST_WAKE_EX,
      ST_CLAMP,
      ST_EMIT_RD,
      ST_EMIT_EX,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

>>> design/ptd_cmp.sv
// ptd_cmp: the shared unsigned compare unit, gives less-than, minimum and maximum
// used by the sequencer for priority, time, due and clamp decisions
// depends on ptd_pkg
`default_nettype none

module ptd_cmp (
   input  ptd_pkg::cmp_req_type req,
   output ptd_pkg::cmp_rsp_type rsp
);
   import ptd_pkg::*;

   logic lt;

   assign lt          = req.lhs < req.rhs;
   assign rsp.lt      = lt;
   assign rsp.min_val = lt ? req.lhs : req.rhs;
   assign rsp.max_val = lt ? req.rhs : req.lhs;

endmodule

`default_nettype wire

>>> design/ptd_table.sv
// ptd_table: handler table memory, one write port and one registered read port
// entries hold id, priority and activation time
// depends on ptd_pkg
`default_nettype none

module ptd_table #(
   parameter int DEPTH = ptd_pkg::MAX_HANDLERS_DEF,
   parameter int IDX_W = 4
) (
   input  logic                clock,
   input  logic                wr_en,
   input  logic [IDX_W-1:0]    wr_addr,
   input  ptd_pkg::entry_type  wr_data,
   input  logic                rd_en,
   input  logic [IDX_W-1:0]    rd_addr,
   output ptd_pkg::entry_type  rd_data
);
   import ptd_pkg::*;

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

>>> design/priority_timed_event_dispatcher.sv
// priority_timed_event_dispatcher: top level, sequencer around the handler table
// and the shared compare unit; output register toward the result channel
// depends on ptd_pkg, ptd_cmp, ptd_table
//
//   channel | ports                       | carries
//   --------+-----------------------------+------------------------------------
//   req     | req_tvalid/tready/tdata/user| op, handler id, priority, times
//   rsp     | rsp_tvalid/tready/tdata/    | due, run id, next wake, full, last
//           | tuser/tlast                 |
//   csr     | csr_wr_en/csr_wr_data       | horizon_ticks
//
// each table entry takes a read state and then a compare state per pass
// add: from the end of the table, entries of lower priority move down one slot until the
// first slot or an entry of equal or higher priority ends the walk; any transaction may
// also wait on rsp_tready
// reset empties the table and restores the horizon; no clearing pass is needed
// req_tready is high only while no transaction is in progress
`default_nettype none

module priority_timed_event_dispatcher #(
   parameter int MAX_HANDLERS = ptd_pkg::MAX_HANDLERS_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   // [3:0] handler_id, [11:4] priority_req, [43:12] activation_time, [75:44] now
   input  logic [79:0] req_tdata,
   // [1:0] op
   input  logic [1:0]  req_tuser,

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [3:0] run_id, [35:4] next_wake
   output logic [39:0] rsp_tdata,
   // [0] due, [1] full_res
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast,

   input  logic        csr_wr_en,
   input  logic [31:0] csr_wr_data
);
   import ptd_pkg::*;

   localparam int CNT_W = $clog2(MAX_HANDLERS + 1);
   localparam int IDX_W = (MAX_HANDLERS > 1) ? $clog2(MAX_HANDLERS) : 1;

   state_type state_ff, state_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic [TIME_W-1:0] horizon_ff;
   logic [TIME_W-1:0] wake_ff, wake_in;

   logic [OP_W-1:0]   op_ff, op_in;
   logic [ID_W-1:0]   id_ff, id_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [TIME_W-1:0] atime_ff, atime_in;
   logic [TIME_W-1:0] now_ff, now_in;
   logic              full_flag_ff, full_flag_in;
   logic              pend_valid_ff, pend_valid_in;
   logic [ID_W-1:0]   pend_id_ff, pend_id_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic              rsp_due_ff, rsp_due_in;
   logic [ID_W-1:0]   rsp_id_ff, rsp_id_in;
   logic [TIME_W-1:0] rsp_wake_ff, rsp_wake_in;
   logic              rsp_full_ff, rsp_full_in;
   logic              rsp_last_ff, rsp_last_in;
   logic              rsp_load;

   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   entry_type         mem_wr_data;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_addr;
   entry_type         rd_entry;

   cmp_req_type       cmp_req;
   cmp_rsp_type       cmp_rsp;

   logic              req_fire;
   logic              out_free;
   logic              scan_end;
   logic              is_full;
   logic [CNT_W-1:0]  idx_m1;
   logic [CNT_W-1:0]  idx_p1;
   logic [CNT_W-1:0]  count_p1;
   logic [OP_W-1:0]   req_op;
   entry_type         new_entry;
   logic              id_match;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign req_op     = req_tuser[OP_W-1:0];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign scan_end   = (idx_ff == count_ff);
   assign is_full    = (count_ff == CNT_W'(MAX_HANDLERS));
   assign idx_m1     = idx_ff - CNT_W'(1);
   assign idx_p1     = idx_ff + CNT_W'(1);
   assign count_p1   = count_ff + CNT_W'(1);
   assign new_entry  = '{id: id_ff, prio: prio_ff, tstamp: atime_ff};
   assign id_match   = (rd_entry.id == id_ff);

   ptd_table #(
      .DEPTH (MAX_HANDLERS),
      .IDX_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (rd_entry)
   );

   ptd_cmp u_cmp (
      .req (cmp_req),
      .rsp (cmp_rsp)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_op == OP_ADD) begin
                  state_in = is_full ? ST_WAKE_RD : ST_INS_RD;
               end else if (req_op == OP_SET) begin
                  state_in = ST_SET_RD;
               end else begin
                  state_in = ST_WAKE_RD;
               end
            end
         end
         ST_INS_RD:  state_in = (idx_ff == '0) ? ST_WAKE_RD : ST_INS_EX;
         ST_INS_EX:  state_in = cmp_rsp.lt ? ST_INS_RD : ST_WAKE_RD;
         ST_SET_RD:  state_in = scan_end ? ST_CLAMP : ST_SET_EX;
         ST_SET_EX:  state_in = ST_SET_RD;
         ST_WAKE_RD: state_in = scan_end ? ST_CLAMP : ST_WAKE_EX;
         ST_WAKE_EX: state_in = ST_WAKE_RD;
         ST_CLAMP:   state_in = (op_ff == OP_TICK) ? ST_EMIT_RD : ST_DONE;
         ST_EMIT_RD: state_in = scan_end ? ST_DONE : ST_EMIT_EX;
         ST_EMIT_EX: begin
            // hold while a due entry must push the pending one out and the slot is busy
            if (!(cmp_rsp.lt && pend_valid_ff && !out_free)) begin
               state_in = ST_EMIT_RD;
            end
         end
         ST_DONE:    state_in = out_free ? ST_IDLE : ST_DONE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // datapath and table control
   always_comb begin
      count_in      = count_ff;
      idx_in        = idx_ff;
      wake_in       = wake_ff;
      op_in         = op_ff;
      id_in         = id_ff;
      prio_in       = prio_ff;
      atime_in      = atime_ff;
      now_in        = now_ff;
      full_flag_in  = full_flag_ff;
      pend_valid_in = pend_valid_ff;
      pend_id_in    = pend_id_ff;

      rsp_load    = 1'b0;
      rsp_due_in  = 1'b0;
      rsp_id_in   = '0;
      rsp_wake_in = wake_ff;
      rsp_full_in = 1'b0;
      rsp_last_in = 1'b0;

      mem_wr_en   = 1'b0;
      mem_wr_addr = idx_ff[IDX_W-1:0];
      mem_wr_data = new_entry;
      mem_rd_en   = 1'b0;
      mem_rd_addr = idx_ff[IDX_W-1:0];

      cmp_req.lhs = rd_entry.tstamp;
      cmp_req.rhs = wake_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in         = req_op;
               id_in         = req_tdata[3:0];
               prio_in       = req_tdata[11:4];
               atime_in      = req_tdata[43:12];
               now_in        = req_tdata[75:44];
               wake_in       = req_tdata[75:44] + horizon_ff;
               full_flag_in  = (req_op == OP_ADD) && is_full;
               pend_valid_in = 1'b0;
               idx_in        = ((req_op == OP_ADD) && !is_full) ? count_ff : '0;
            end
         end
         ST_INS_RD: begin
            if (idx_ff == '0) begin
               mem_wr_en   = 1'b1;
               mem_wr_addr = '0;
               count_in    = count_p1;
            end else begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_m1[IDX_W-1:0];
            end
         end
         ST_INS_EX: begin
            cmp_req.lhs = {{(TIME_W-PRIO_W){1'b0}}, rd_entry.prio};
            cmp_req.rhs = {{(TIME_W-PRIO_W){1'b0}}, prio_ff};
            mem_wr_en   = 1'b1;
            if (cmp_rsp.lt) begin
               // lower priority entry moves one slot down
               mem_wr_data = rd_entry;
               idx_in      = idx_m1;
            end else begin
               count_in = count_p1;
               idx_in   = '0;
            end
         end
         ST_SET_RD, ST_WAKE_RD, ST_EMIT_RD: begin
            mem_rd_en = !scan_end;
         end
         ST_SET_EX: begin
            cmp_req.lhs = id_match ? atime_ff : rd_entry.tstamp;
            wake_in     = cmp_rsp.min_val;
            mem_wr_en   = id_match;
            mem_wr_data = '{id: rd_entry.id, prio: rd_entry.prio, tstamp: atime_ff};
            idx_in      = idx_p1;
         end
         ST_WAKE_EX: begin
            wake_in = cmp_rsp.min_val;
            idx_in  = idx_p1;
         end
         ST_CLAMP: begin
            cmp_req.lhs = wake_ff;
            cmp_req.rhs = now_ff;
            wake_in     = cmp_rsp.max_val;
            idx_in      = '0;
         end
         ST_EMIT_EX: begin
            cmp_req.rhs = now_ff;
            if (!cmp_rsp.lt) begin
               idx_in = idx_p1;
            end else if (!pend_valid_ff) begin
               pend_valid_in = 1'b1;
               pend_id_in    = rd_entry.id;
               idx_in        = idx_p1;
            end else if (out_free) begin
               // the held due entry is not the final one
               rsp_load   = 1'b1;
               rsp_due_in = 1'b1;
               rsp_id_in  = pend_id_ff;
               pend_id_in = rd_entry.id;
               idx_in     = idx_p1;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_load    = 1'b1;
               rsp_due_in  = pend_valid_ff;
               rsp_id_in   = pend_valid_ff ? pend_id_ff : '0;
               rsp_full_in = full_flag_ff;
               rsp_last_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         horizon_ff   <= HORIZON_RESET;
         rsp_valid_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
         if (csr_wr_en) begin
            horizon_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      wake_ff      <= wake_in;
      op_ff        <= op_in;
      id_ff        <= id_in;
      prio_ff      <= prio_in;
      atime_ff     <= atime_in;
      now_ff       <= now_in;
      full_flag_ff <= full_flag_in;
      pend_id_ff   <= pend_id_in;
      if (rsp_load) begin
         rsp_due_ff  <= rsp_due_in;
         rsp_id_ff   <= rsp_id_in;
         rsp_wake_ff <= rsp_wake_in;
         rsp_full_ff <= rsp_full_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, rsp_wake_ff, rsp_id_ff};
   assign rsp_tuser  = {rsp_full_ff, rsp_due_ff};
   assign rsp_tlast  = rsp_last_ff;

   count_in_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_HANDLERS))
      else $error("handler count beyond table depth");

   full_add_keeps_count: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_op == OP_ADD && is_full) |=> count_ff == $past(count_ff))
      else $error("refused add changed the handler count");

   write_only_when_updating: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_INS_RD || state_ff == ST_INS_EX ||
                     state_ff == ST_SET_EX))
      else $error("table written outside insert or set");

   pending_only_on_tick: assert property (@(posedge clock) disable iff (reset)
      (pend_valid_ff && state_ff != ST_IDLE) |-> op_ff == OP_TICK)
      else $error("due entry held outside a tick");

   last_only_from_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_load && rsp_last_in) |-> state_ff == ST_DONE)
      else $error("final transaction issued before the scan ended");

endmodule

`default_nettype wire
